// ----- hdl/cll_pkg.sv -----
// cll_pkg: types, constants and opcode codes for the cursor linked list engine
// no dependencies
`timescale 1ns / 1ps
package cll_pkg;
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int IDX_W  = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(SLOTS);

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0, OP_INS_REAR = 3'd1, OP_RM_FRONT = 3'd2, OP_RM_REAR = 3'd3,
    OP_RM_CUR = 3'd4, OP_FIND_NUM = 3'd5, OP_FIND_NAME = 3'd6, OP_CLEAR = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_WALK, S_POP, S_FILL, S_UNLINK, S_FINAL, S_OUT
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] key_number;
    logic [63:0]        key_name;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         current_slot;
    logic signed [31:0] current_number;
    logic [63:0]        current_name;
  } out_word_t;

  // one slot of the store
  typedef struct packed {
    logic [SLOT_W-1:0] next_link;
    logic [SLOT_W-1:0] free_link;
    logic [31:0]       number;
    logic [63:0]       name;
  } slot_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_t             wr_data;
  } mem_req_t;

  function automatic logic is_slot(logic [SLOT_W-1:0] s);
    return s < NONE_SLOT;
  endfunction
endpackage

// ----- hdl/cll_store.sv -----
// cll_store: slot memory, one read and one write port, registered read
// depends on cll_pkg
`timescale 1ns / 1ps
module cll_store (
  input  logic              clk,
  input  cll_pkg::mem_req_t req,
  output cll_pkg::slot_t    rd_data
);
  import cll_pkg::*;

  slot_t mem [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
  end

  // read port, forwards a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && req.wr_addr == req.rd_addr) rd_data <= req.wr_data;
      else rd_data <= mem[req.rd_addr];
    end
  end
endmodule

// ----- hdl/cll_seq.sv -----
// cll_seq: operation sequencer, walks the links one slot per read
// depends on cll_pkg
`timescale 1ns / 1ps
module cll_seq (
  input  logic               clk,
  input  logic               rst,
  input  cll_pkg::in_word_t  in_word,
  input  logic               in_valid,
  output logic               in_ready,
  output cll_pkg::out_word_t out_word,
  output logic               out_valid,
  input  logic               out_ready,
  output cll_pkg::mem_req_t  req,
  input  cll_pkg::slot_t     rd_data
);
  import cll_pkg::*;

  state_t state, state_next;
  in_word_t cmd;
  logic [SLOT_W-1:0] head, cursor, used, fhead;
  logic [SLOT_W-1:0] p, pre, link;  // walk position, its predecessor, relink target
  slot_t             prev_data;     // entry of pre as read during the walk
  status_t           st;

  logic [SLOT_W-1:0] head_next, cursor_next, used_next, fhead_next;
  logic [SLOT_W-1:0] p_next, pre_next, link_next;
  slot_t             prev_data_next;
  status_t           st_next;

  logic [SLOT_W-1:0] new_slot;
  logic              have_slot;
  logic              is_insert;
  logic              at_front;
  logic              hit;
  logic              rm_here;
  logic              advance;
  logic              rd_e;
  logic [IDX_W-1:0]  rd_a;
  logic              wr_e;
  logic [IDX_W-1:0]  wr_a;
  slot_t             wr_d;

  assign in_ready = (state == S_IDLE);

  // slot allocation: free stack first, then high-water
  always_comb begin
    have_slot = 1'b1;
    new_slot  = fhead;
    if (!is_slot(fhead)) begin
      new_slot  = used;
      have_slot = used < NONE_SLOT;
    end
  end

  // operation decode and walk decisions on the slot at p
  always_comb begin
    is_insert = (cmd.opcode == OP_INS_FRONT) || (cmd.opcode == OP_INS_REAR);
    at_front  = (cmd.opcode == OP_INS_FRONT) || !is_slot(head);
    hit = (cmd.opcode == OP_FIND_NAME) ? (rd_data.name == cmd.key_name)
                                       : (rd_data.number == cmd.key_number);
    unique case (cmd.opcode)
      OP_RM_FRONT: rm_here = 1'b1;
      OP_RM_REAR:  rm_here = !is_slot(rd_data.next_link);
      OP_RM_CUR:   rm_here = (p == cursor);
      default:     rm_here = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (is_insert && at_front) begin
          if (!have_slot) state_next = S_FINAL;
          else if (is_slot(fhead)) state_next = S_POP;
          else state_next = S_FILL;
        end else if (!is_slot(head) || (cmd.opcode == OP_RM_CUR && !is_slot(cursor)))
          state_next = S_FINAL;
        else state_next = S_WALK;
      end
      S_WALK: begin
        unique case (cmd.opcode)
          OP_INS_REAR: begin
            if (!is_slot(rd_data.next_link)) begin
              if (!have_slot) state_next = S_FINAL;
              else if (is_slot(fhead)) state_next = S_POP;
              else state_next = S_FILL;
            end
          end
          OP_FIND_NUM, OP_FIND_NAME:
            if (hit || !is_slot(rd_data.next_link)) state_next = S_FINAL;
          OP_CLEAR: if (!is_slot(rd_data.next_link)) state_next = S_FINAL;
          default: begin
            if (rm_here) state_next = (p == head) ? S_FINAL : S_UNLINK;
            else if (!is_slot(rd_data.next_link)) state_next = S_FINAL;
          end
        endcase
      end
      S_POP:    state_next = S_FILL;
      S_FILL:   state_next = S_FINAL;
      S_UNLINK: state_next = S_FINAL;
      S_FINAL:  state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_next = head; cursor_next = cursor; used_next = used; fhead_next = fhead;
    p_next = p; pre_next = pre; link_next = link; prev_data_next = prev_data;
    st_next = st; advance = 1'b0;
    rd_e = 1'b0; rd_a = '0; wr_e = 1'b0; wr_a = '0; wr_d = '0;
    unique case (state)
      S_IDLE: ;
      S_DISPATCH: begin
        st_next = ST_OK; p_next = head; pre_next = NONE_SLOT;
        if (is_insert && at_front) begin
          if (!have_slot) st_next = ST_FULL;
          else begin
            p_next = new_slot;
            // popping the free stack needs the popped entry's free link
            if (is_slot(fhead)) begin
              rd_e = 1'b1; rd_a = fhead[IDX_W-1:0];
            end else used_next = used + 1'b1;
          end
        end else if (!is_slot(head)) begin
          if (cmd.opcode == OP_FIND_NUM || cmd.opcode == OP_FIND_NAME)
            st_next = ST_NOT_FOUND;
          else if (cmd.opcode != OP_CLEAR) st_next = ST_EMPTY;
        end else if (cmd.opcode == OP_RM_CUR && !is_slot(cursor)) st_next = ST_EMPTY;
        else begin
          rd_e = 1'b1; rd_a = head[IDX_W-1:0];
        end
        if (cmd.opcode == OP_CLEAR) cursor_next = NONE_SLOT;
      end
      S_WALK: begin
        // rd_data holds slot p
        unique case (cmd.opcode)
          OP_INS_REAR: begin
            if (is_slot(rd_data.next_link)) advance = 1'b1;
            else if (!have_slot) st_next = ST_FULL;
            else begin
              // link the tail to the new slot
              wr_e = 1'b1; wr_a = p[IDX_W-1:0]; wr_d = rd_data;
              wr_d.next_link = new_slot;
              p_next = new_slot;
              if (is_slot(fhead)) begin
                rd_e = 1'b1; rd_a = fhead[IDX_W-1:0];
              end else used_next = used + 1'b1;
            end
          end
          OP_FIND_NUM, OP_FIND_NAME: begin
            if (hit) cursor_next = p;
            else if (is_slot(rd_data.next_link)) advance = 1'b1;
            else st_next = ST_NOT_FOUND;
          end
          OP_CLEAR: begin
            // push p onto the free stack and move the head on
            wr_e = 1'b1; wr_a = p[IDX_W-1:0]; wr_d = rd_data; wr_d.free_link = fhead;
            fhead_next = p; head_next = rd_data.next_link;
            if (is_slot(rd_data.next_link)) advance = 1'b1;
          end
          default: begin
            // removals: free p, then fix the head or the predecessor's link
            if (rm_here) begin
              wr_e = 1'b1; wr_a = p[IDX_W-1:0]; wr_d = rd_data; wr_d.free_link = fhead;
              fhead_next = p;
              if (p == head) begin
                head_next = rd_data.next_link; cursor_next = rd_data.next_link;
              end else begin
                cursor_next = pre; link_next = rd_data.next_link;
              end
            end else if (is_slot(rd_data.next_link)) advance = 1'b1;
            else st_next = ST_EMPTY;
          end
        endcase
        if (advance) begin
          pre_next = p; prev_data_next = rd_data; p_next = rd_data.next_link;
          rd_e = 1'b1; rd_a = rd_data.next_link[IDX_W-1:0];
        end
      end
      S_POP: fhead_next = rd_data.free_link;
      S_FILL: begin
        wr_e = 1'b1; wr_a = p[IDX_W-1:0];
        wr_d.number = cmd.key_number; wr_d.name = cmd.key_name;
        wr_d.free_link = NONE_SLOT;
        wr_d.next_link = at_front ? head : NONE_SLOT;
        if (at_front) head_next = p;
        cursor_next = p;
      end
      S_UNLINK: begin
        wr_e = 1'b1; wr_a = pre[IDX_W-1:0]; wr_d = prev_data; wr_d.next_link = link;
      end
      S_FINAL: begin
        // fetch the current entry for the result word
        if (is_slot(cursor)) begin
          rd_e = 1'b1; rd_a = cursor[IDX_W-1:0];
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head <= NONE_SLOT; cursor <= NONE_SLOT;
      used <= '0; fhead <= NONE_SLOT;
    end else begin
      state <= state_next; head <= head_next; cursor <= cursor_next;
      used <= used_next; fhead <= fhead_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) cmd <= in_word;
    p <= p_next; pre <= pre_next; link <= link_next;
    prev_data <= prev_data_next; st <= st_next;
  end

  // result word
  assign out_valid = (state == S_OUT);
  always_comb begin
    out_word.status = st;
    out_word.current_slot = 5'(cursor);
    out_word.current_number = is_slot(cursor) ? rd_data.number : '0;
    out_word.current_name = is_slot(cursor) ? rd_data.name : '0;
  end

  assign req.rd_en = rd_e;
  assign req.rd_addr = rd_a;
  assign req.wr_en = wr_e;
  assign req.wr_addr = wr_a;
  assign req.wr_data = wr_d;
endmodule

// ----- hdl/cursor_linked_list_engine.sv -----
// cursor_linked_list_engine: top level, sequencer plus slot memory
// depends on cll_pkg, cll_seq, cll_store
`timescale 1ns / 1ps
// One word in, one result word out per operation. A word is taken only in
// idle, and no new word is taken until the result word has been taken. Front
// insert takes an extra pop step when a slot is popped from the free stack.
// Rear insert, rear and current removal, searches and clear walk the links
// one slot per memory read. The single read port of the slot memory sets the
// walk rate.
module cursor_linked_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  cll_pkg::in_word_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output cll_pkg::out_word_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import cll_pkg::*;

  mem_req_t req;
  slot_t    rd_data;

  cll_seq u_seq (
    .clk, .rst, .in_word(in_data), .in_valid, .in_ready,
    .out_word(out_data), .out_valid, .out_ready, .req, .rd_data
  );

  cll_store u_store (.clk, .req, .rd_data);
endmodule

// ----- tb/cursor_linked_list_engine_tb.sv -----
// cursor_linked_list_engine_tb: self-checking bench for the cursor linked list engine
// depends on cll_pkg and the cursor_linked_list_engine rtl
`timescale 1ns / 1ps
module cursor_linked_list_engine_tb;
  import cll_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int RANDOM_WORDS    = 730;

  logic      clk;
  logic      rst;
  in_word_t  in_data;
  logic      in_valid;
  logic      in_ready;
  out_word_t out_data;
  logic      out_valid;
  logic      out_ready;

  cursor_linked_list_engine dut (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shadow copy of the list store
  logic [4:0]  sh_next [SLOTS];
  logic [4:0]  sh_free [SLOTS];
  logic [31:0] sh_num  [SLOTS];
  logic [63:0] sh_name [SLOTS];
  logic [4:0]  sh_head, sh_cursor, sh_mark, sh_free_head;

  out_word_t  result_queue[$];
  logic       check_queue[$];   // 1: fixed value typed into the table must match too
  out_word_t  typed_queue[$];
  int         mismatches;
  bit         idle_enable;

  function automatic bit valid_slot(logic [4:0] s);
    return s < SLOTS;
  endfunction

  function automatic logic [4:0] alloc_slot();
    logic [4:0] s;
    if (valid_slot(sh_free_head)) begin
      s = sh_free_head;
      sh_free_head = sh_free[s];
      return s;
    end
    if (sh_mark < SLOTS) begin
      s = sh_mark;
      sh_mark++;
      return s;
    end
    return NONE_SLOT;
  endfunction

  function automatic void release_slot(logic [4:0] s);
    if (!valid_slot(s)) return;
    sh_free[s] = sh_free_head;
    sh_free_head = s;
  endfunction

  function automatic status_t drop_front();
    logic [4:0] old;
    old = sh_head;
    if (!valid_slot(old)) return ST_EMPTY;
    sh_head = sh_next[old];
    release_slot(old);
    sh_cursor = sh_head;
    return ST_OK;
  endfunction

  function automatic status_t add_front(logic [31:0] n, logic [63:0] nm);
    logic [4:0] s;
    s = alloc_slot();
    if (!valid_slot(s)) return ST_FULL;
    sh_num[s] = n; sh_name[s] = nm; sh_next[s] = sh_head;
    sh_head = s;
    sh_cursor = s;
    return ST_OK;
  endfunction

  // compute the result word for one operation and advance the shadow list
  function automatic out_word_t apply_list_op(in_word_t w);
    status_t    st;
    logic [4:0] p, pre, s;
    bit         done;
    out_word_t  r;
    st = ST_OK;
    case (w.opcode)
      OP_INS_FRONT: st = add_front(w.key_number, w.key_name);
      OP_INS_REAR: begin
        if (!valid_slot(sh_head)) st = add_front(w.key_number, w.key_name);
        else begin
          p = sh_head;
          for (int i = 0; i < SLOTS; i++) begin
            if (!valid_slot(sh_next[p])) break;
            p = sh_next[p];
          end
          s = alloc_slot();
          if (!valid_slot(s)) st = ST_FULL;
          else begin
            sh_num[s] = w.key_number; sh_name[s] = w.key_name; sh_next[s] = NONE_SLOT;
            sh_next[p] = s;
            sh_cursor = s;
          end
        end
      end
      OP_RM_FRONT: st = drop_front();
      OP_RM_REAR: begin
        if (!valid_slot(sh_head)) st = ST_EMPTY;
        else if (!valid_slot(sh_next[sh_head])) st = drop_front();
        else begin
          pre = sh_head;
          p = sh_next[sh_head];
          for (int i = 0; i < SLOTS; i++) begin
            if (!valid_slot(sh_next[p])) break;
            pre = p;
            p = sh_next[p];
          end
          sh_next[pre] = NONE_SLOT;
          release_slot(p);
          sh_cursor = pre;
        end
      end
      OP_RM_CUR: begin
        if (!valid_slot(sh_head) || !valid_slot(sh_cursor)) st = ST_EMPTY;
        else if (sh_cursor == sh_head) st = drop_front();
        else begin
          st = ST_EMPTY;
          done = 1'b0;
          p = sh_head;
          for (int i = 0; i < SLOTS && !done; i++) begin
            if (sh_next[p] == sh_cursor) begin
              sh_next[p] = sh_next[sh_cursor];
              release_slot(sh_cursor);
              sh_cursor = p;
              st = ST_OK;
              done = 1'b1;
            end else begin
              p = sh_next[p];
              if (!valid_slot(p)) done = 1'b1;
            end
          end
        end
      end
      OP_FIND_NUM, OP_FIND_NAME: begin
        st = ST_NOT_FOUND;
        p = sh_head;
        for (int i = 0; i < SLOTS && valid_slot(p); i++) begin
          if ((w.opcode == OP_FIND_NAME) ? (sh_name[p] == w.key_name)
                                         : (sh_num[p] == w.key_number)) begin
            sh_cursor = p;
            st = ST_OK;
            break;
          end
          p = sh_next[p];
        end
      end
      default: begin
        for (int i = 0; i < SLOTS && valid_slot(sh_head); i++) void'(drop_front());
        sh_cursor = NONE_SLOT;
      end
    endcase
    r.status = st;
    if (valid_slot(sh_cursor)) begin
      r.current_slot = sh_cursor;
      r.current_number = sh_num[sh_cursor];
      r.current_name = sh_name[sh_cursor];
    end else begin
      r.current_slot = NONE_SLOT;
      r.current_number = '0;
      r.current_name = '0;
    end
    return r;
  endfunction

  // directed table: opcode, number, name, typed result valid, typed result
  typedef struct {
    opcode_t     op;
    logic [31:0] n;
    logic [63:0] nm;
    bit          typed;
    out_word_t   res;
  } table_row_t;

  table_row_t directed[$];

  function automatic void add_row(opcode_t op, logic [31:0] n, logic [63:0] nm,
                                  bit typed = 0, status_t st = ST_OK,
                                  logic [4:0] cs = NONE_SLOT, logic [31:0] cn = 0,
                                  logic [63:0] cnm = 0);
    table_row_t row;
    row.op = op; row.n = n; row.nm = nm; row.typed = typed;
    row.res = '{status: st, current_slot: cs, current_number: cn, current_name: cnm};
    directed.push_back(row);
  endfunction

  function automatic void build_table();
    // empty list after reset
    add_row(OP_RM_FRONT, 0, 0, 1, ST_EMPTY);
    add_row(OP_RM_REAR, 0, 0, 1, ST_EMPTY);
    add_row(OP_RM_CUR, 0, 0, 1, ST_EMPTY);
    add_row(OP_FIND_NUM, 0, 0, 1, ST_NOT_FOUND);
    add_row(OP_FIND_NAME, 0, 0, 1, ST_NOT_FOUND);
    add_row(OP_CLEAR, 0, 0, 1, ST_OK);
    // extremes of the fields
    add_row(OP_INS_FRONT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 0,
            32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    add_row(OP_INS_REAR, 32'h7FFF_FFFF, 64'h0, 1, ST_OK, 1, 32'h7FFF_FFFF, 64'h0);
    add_row(OP_INS_REAR, 32'hFFFF_FFFF, 64'h4142_4344_4546_4748);
    add_row(OP_FIND_NUM, 32'h8000_0000, 0);
    add_row(OP_FIND_NAME, 0, 64'h4142_4344_4546_4748);
    add_row(OP_FIND_NAME, 0, 64'h1);
    add_row(OP_RM_CUR, 0, 0);
    add_row(OP_RM_REAR, 0, 0);
    add_row(OP_RM_CUR, 0, 0);
    add_row(OP_RM_FRONT, 0, 0);
    // fill the store to full, then overflow
    for (int i = 0; i < SLOTS; i++) add_row(OP_INS_REAR, i, 64'(i) << 56);
    add_row(OP_INS_FRONT, 1, 1);
    add_row(OP_INS_REAR, 1, 1);
    add_row(OP_CLEAR, 0, 0, 1, ST_OK);
  endfunction

  // one word onto the input channel, with random gaps; valid stays up after
  // the accepting edge until the next gap or the next word
  task automatic send_word(in_word_t w);
    while (idle_enable && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // record prediction at the accepting edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) result_queue.push_back(apply_list_op(in_data));
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !idle_enable || ($urandom_range(99) >= 28);
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t typed_w;
    bit        typed;
    if (!rst && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        exp_w = result_queue.pop_front();
        typed = check_queue.pop_front();
        typed_w = typed_queue.pop_front();
        if (typed && typed_w != exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("table row disagrees: typed %h predicted %h",
                                         typed_w, exp_w);
        end
        if (out_data.status !== exp_w.status ||
            out_data.current_slot !== exp_w.current_slot ||
            out_data.current_number !== exp_w.current_number ||
            out_data.current_name !== exp_w.current_name) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %h actual %h", exp_w, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int stall_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("cursor_linked_list_engine: mismatch");
      $finish;
    end
  end

  // random word, mostly inserts and hits on live contents
  function automatic in_word_t random_word();
    in_word_t   w;
    int unsigned pick;
    logic [4:0] p;
    int         hops;
    w.key_number = $urandom;
    w.key_name = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 22) w.opcode = OP_INS_FRONT;
    else if (pick < 44) w.opcode = OP_INS_REAR;
    else if (pick < 52) w.opcode = OP_RM_FRONT;
    else if (pick < 60) w.opcode = OP_RM_REAR;
    else if (pick < 72) w.opcode = OP_RM_CUR;
    else if (pick < 84) w.opcode = OP_FIND_NUM;
    else if (pick < 96) w.opcode = OP_FIND_NAME;
    else w.opcode = OP_CLEAR;
    // small key space so searches hit and duplicates occur
    if ($urandom_range(1)) begin
      w.key_number = $urandom_range(7);
      w.key_name = 64'($urandom_range(7));
    end
    // aim a search at a live node picked from the shadow list
    if ((w.opcode == OP_FIND_NUM || w.opcode == OP_FIND_NAME) &&
        valid_slot(sh_head) && $urandom_range(2) != 0) begin
      p = sh_head;
      hops = $urandom_range(SLOTS - 1);
      for (int i = 0; i < hops && valid_slot(sh_next[p]); i++) p = sh_next[p];
      w.key_number = sh_num[p];
      w.key_name = sh_name[p];
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    in_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    rst = 1'b1;
    mismatches = 0;
    idle_enable = 1'b1;
    sh_head = NONE_SLOT; sh_cursor = NONE_SLOT; sh_free_head = NONE_SLOT; sh_mark = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_next[i] = 0; sh_free[i] = 0; sh_num[i] = 0; sh_name[i] = 0;
    end
    build_table();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed table
    foreach (directed[i]) begin
      w.opcode = directed[i].op;
      w.key_number = directed[i].n;
      w.key_name = directed[i].nm;
      check_queue.push_back(directed[i].typed);
      typed_queue.push_back(directed[i].res);
      send_word(w);
    end
    // random part; a stretch in the middle runs without idling
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_enable = !(i >= 250 && i < 400);
      w = random_word();
      check_queue.push_back(1'b0);
      typed_queue.push_back('0);
      send_word(w);
    end
    in_valid <= 1'b0;
    idle_enable = 1'b1;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("cursor_linked_list_engine: match");
    else $display("cursor_linked_list_engine: mismatch");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/cll_pkg.sv
hdl/cll_store.sv
hdl/cll_seq.sv
hdl/cursor_linked_list_engine.sv
tb/cursor_linked_list_engine_tb.sv
